// File: hdl/v6ehw_pkg.sv
// ----------------------------------------------------------------------------
// v6ehw_pkg - shared types and constants of the IPv6 extension header walker
// Protocol numbers, field widths and the request/result records.
// ----------------------------------------------------------------------------
`default_nettype none

package v6ehw_pkg;

   // Width of the length and offset arithmetic (12 to 16).
   localparam int LEN_W = 16;
   // Position inside one header; the longest header is 2048 bytes.
   localparam int IDX_W = 11;
   // Header length before the decrement (up to 2048).
   localparam int HLEN_W = IDX_W + 1;

   localparam logic [7:0] PROTO_HOPOPTS  = 8'd0;
   localparam logic [7:0] PROTO_ROUTING  = 8'd43;
   localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
   localparam logic [7:0] PROTO_AH       = 8'd51;
   localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;

   localparam logic [15:0] FRAG_OFFSET_MASK = 16'hFFF8;
   localparam logic [LEN_W-1:0] MIN_HDR_BYTES = LEN_W'(8);
   localparam logic [IDX_W-1:0] FRAG_HDR_LAST = IDX_W'(7);

   typedef struct packed {
      logic [7:0]       data_byte;
      logic             first_byte;
      logic             last_byte;
      logic [7:0]       initial_next_header;
      logic [15:0]      available_length;
   } item_type;

   typedef struct packed {
      logic             walk_ok;
      logic [7:0]       next_protocol;
      logic [1:0]       frag_flags;
      logic [15:0]      consumed_length;
      logic             frag_header_seen;
      logic [15:0]      frag_header_offset;
   } result_type;

   function automatic logic is_ext(input logic [7:0] proto);
      return (proto == PROTO_HOPOPTS) || (proto == PROTO_ROUTING) ||
             (proto == PROTO_DSTOPTS) || (proto == PROTO_AH) ||
             (proto == PROTO_FRAGMENT);
   endfunction

endpackage

`default_nettype wire

// File: hdl/ipv6_ext_header_walker.sv
// ----------------------------------------------------------------------------
// ipv6_ext_header_walker - IPv6 extension header chain walker
// Walks hop-by-hop, routing, destination options, AH and fragment headers
// one byte per request and reports the upper-layer protocol of the chain.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   req     | req_valid/req_ready  | data_byte, first/last_byte, next header,
//           |                      | available length
//   rsp     | rsp_valid/rsp_ready  | walk_ok, next_protocol, frag_flags,
//           |                      | consumed/offset lengths, frag seen
//
// One request per cycle sustained while req_ready is high. A request is
// registered in the input register at its accepting edge; the walk step runs
// on it while the skid entry is free, and any result goes to the output
// register, or to the skid entry while the output register is held.
// Reset clears the walk state and all valid flags; no walk is active after.
// A one-entry skid register behind the output register absorbs a result
// while rsp_ready is low; req_ready drops only while the skid entry and the
// input register are both full.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_ext_header_walker
   import v6ehw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   input  wire logic        req_last_byte,
   input  wire logic [7:0]  req_initial_next_header,
   input  wire logic [15:0] req_available_length,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_walk_ok,
   output      logic [7:0]  rsp_next_protocol,
   output      logic [1:0]  rsp_frag_flags,
   output      logic [15:0] rsp_consumed_length,
   output      logic        rsp_frag_header_seen,
   output      logic [15:0] rsp_frag_header_offset
);

   // input register
   logic       in_valid_ff;
   item_type   in_item_ff;

   // output register and skid entry
   logic       out_valid_ff;
   result_type out_res_ff;
   logic       skid_valid_ff;
   result_type skid_res_ff;

   logic       step_en;
   logic       emit;
   result_type step_res;
   logic       req_take;
   logic       rsp_take;

   // the step may run whenever the skid entry is free: its result always fits
   assign step_en   = in_valid_ff && !skid_valid_ff;
   assign req_ready = !in_valid_ff || !skid_valid_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_take  = out_valid_ff && rsp_ready;

   v6ehw_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .emit    (emit),
      .result  (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (step_en) begin
            in_valid_ff <= 1'b0;
         end

         if (skid_valid_ff) begin
            // no step runs while the skid entry is full
            if (rsp_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (emit) begin
            if (!out_valid_ff || rsp_take) begin
               out_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.data_byte           <= req_data_byte;
         in_item_ff.first_byte          <= req_first_byte;
         in_item_ff.last_byte           <= req_last_byte;
         in_item_ff.initial_next_header <= req_initial_next_header;
         in_item_ff.available_length    <= req_available_length;
      end
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_res_ff <= skid_res_ff;
         end
      end else if (emit) begin
         if (!out_valid_ff || rsp_take) begin
            out_res_ff <= step_res;
         end else begin
            skid_res_ff <= step_res;
         end
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_walk_ok            = out_res_ff.walk_ok;
   assign rsp_next_protocol      = out_res_ff.next_protocol;
   assign rsp_frag_flags         = out_res_ff.frag_flags;
   assign rsp_consumed_length    = out_res_ff.consumed_length;
   assign rsp_frag_header_seen   = out_res_ff.frag_header_seen;
   assign rsp_frag_header_offset = out_res_ff.frag_header_offset;

`ifndef ASSERT_OFF
   // skid entry fills only behind a held output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output register valid");

   // backpressure only when a request is parked and the skid entry is full
   a_ready_low_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && skid_valid_ff))
      else $error("req_ready low without a full pipeline");

   // a later fragment always ends the walk successfully on protocol 44
   a_later_frag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frag_flags[1]) |->
         (rsp_frag_flags[0] && rsp_walk_ok && rsp_next_protocol == PROTO_FRAGMENT))
      else $error("later fragment result inconsistent");

   // offset reported only when a fragment header was met
   a_frag_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frag_header_seen) |->
         (rsp_frag_header_offset == 16'h0000 && rsp_frag_flags == 2'b00))
      else $error("fragment fields set without a fragment header");
`endif

endmodule

`default_nettype wire

// File: hdl/v6ehw_walk.sv
// ----------------------------------------------------------------------------
// v6ehw_walk - chain walk state and per-byte step
// Holds the walk state and advances it by one byte per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module v6ehw_walk
   import v6ehw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire item_type   item,
   output      logic       emit,
   output      result_type result
);

   logic [7:0]       cur_proto_ff, cur_proto_in;
   logic [7:0]       pend_next_ff, pend_next_in;
   logic [IDX_W-1:0] hdr_idx_ff, hdr_idx_in;
   logic [IDX_W-1:0] hdr_len_ff, hdr_len_in;
   logic [LEN_W-1:0] remain_ff, remain_in;
   logic [LEN_W-1:0] offset_ff, offset_in;
   logic [15:0]      frag_word_ff, frag_word_in;
   logic [1:0]       frag_state_ff, frag_state_in;
   logic             frag_found_ff, frag_found_in;
   logic [LEN_W-1:0] frag_pos_ff, frag_pos_in;
   logic             active_ff, active_in;

   always_comb begin
      logic             done;
      logic             ok;
      logic [7:0]       proto;
      logic             is_frag;
      logic [HLEN_W-1:0] len;
      logic [LEN_W-1:0] hlen_full;

      done          = 1'b0;
      ok            = 1'b0;
      proto         = '0;
      is_frag       = 1'b0;
      len           = '0;
      hlen_full     = '0;
      cur_proto_in  = cur_proto_ff;
      pend_next_in  = pend_next_ff;
      hdr_idx_in    = hdr_idx_ff;
      hdr_len_in    = hdr_len_ff;
      remain_in     = remain_ff;
      offset_in     = offset_ff;
      frag_word_in  = frag_word_ff;
      frag_state_in = frag_state_ff;
      frag_found_in = frag_found_ff;
      frag_pos_in   = frag_pos_ff;
      active_in     = active_ff;

      // a first byte drops any walk in progress and starts fresh
      if (item.first_byte) begin
         cur_proto_in  = item.initial_next_header;
         pend_next_in  = '0;
         hdr_idx_in    = '0;
         hdr_len_in    = '0;
         remain_in     = item.available_length[LEN_W-1:0];
         offset_in     = '0;
         frag_word_in  = '0;
         frag_state_in = '0;
         frag_found_in = 1'b0;
         frag_pos_in   = '0;
         active_in     = 1'b1;
      end

      if (active_in) begin
         if (hdr_idx_in == '0) begin
            if (!is_ext(cur_proto_in)) begin
               done  = 1'b1;
               ok    = 1'b1;
               proto = cur_proto_in;
            end else if (remain_in < MIN_HDR_BYTES) begin
               done  = 1'b1;
               proto = cur_proto_in;
            end else begin
               pend_next_in = item.data_byte;
               if (cur_proto_in == PROTO_FRAGMENT) begin
                  frag_found_in = 1'b1;
                  frag_pos_in   = offset_in;
                  hdr_len_in    = FRAG_HDR_LAST;
                  frag_word_in  = '0;
               end
               hdr_idx_in = IDX_W'(1);
            end
         end else begin
            is_frag = (cur_proto_in == PROTO_FRAGMENT);
            if (hdr_idx_in == IDX_W'(1) && !is_frag) begin
               if (cur_proto_in == PROTO_AH) begin
                  len = (HLEN_W'(item.data_byte) + HLEN_W'(2)) << 2;
               end else begin
                  len = (HLEN_W'(item.data_byte) + HLEN_W'(1)) << 3;
               end
               if (LEN_W'(len) > remain_in) begin
                  done  = 1'b1;
                  proto = pend_next_in;
               end else begin
                  hdr_len_in = IDX_W'(len - HLEN_W'(1));
               end
            end
            if (!done) begin
               if (is_frag && hdr_idx_in == IDX_W'(2)) begin
                  frag_word_in = {item.data_byte, 8'h00};
               end
               if (is_frag && hdr_idx_in == IDX_W'(3)) begin
                  frag_word_in = {frag_word_in[15:8], item.data_byte};
               end
               if (hdr_idx_in >= hdr_len_in) begin
                  hlen_full    = LEN_W'(hdr_len_in) + LEN_W'(1);
                  remain_in    = remain_in - hlen_full;
                  offset_in    = offset_in + hlen_full;
                  cur_proto_in = pend_next_in;
                  hdr_idx_in   = '0;
                  if (is_frag && frag_word_in != '0) begin
                     frag_state_in = 2'b01;
                     // non-zero fragment offset: later fragment, stop here
                     if ((frag_word_in & FRAG_OFFSET_MASK) != '0) begin
                        frag_state_in = 2'b11;
                        done  = 1'b1;
                        ok    = 1'b1;
                        proto = PROTO_FRAGMENT;
                     end
                  end
               end else begin
                  hdr_idx_in = hdr_idx_in + IDX_W'(1);
               end
            end
         end

         if (!done && item.last_byte) begin
            done  = 1'b1;
            ok    = (hdr_idx_in == '0) && !is_ext(cur_proto_in);
            proto = cur_proto_in;
         end
         if (done) begin
            active_in = 1'b0;
         end
      end

      emit                      = step_en && done;
      result.walk_ok            = ok;
      result.next_protocol      = proto;
      result.frag_flags         = frag_state_in;
      result.consumed_length    = 16'(offset_in);
      result.frag_header_seen   = frag_found_in;
      result.frag_header_offset = frag_found_in ? 16'(frag_pos_in) : 16'h0000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_proto_ff  <= '0;
         pend_next_ff  <= '0;
         hdr_idx_ff    <= '0;
         hdr_len_ff    <= '0;
         remain_ff     <= '0;
         offset_ff     <= '0;
         frag_word_ff  <= '0;
         frag_state_ff <= '0;
         frag_found_ff <= 1'b0;
         frag_pos_ff   <= '0;
         active_ff     <= 1'b0;
      end else if (step_en) begin
         cur_proto_ff  <= cur_proto_in;
         pend_next_ff  <= pend_next_in;
         hdr_idx_ff    <= hdr_idx_in;
         hdr_len_ff    <= hdr_len_in;
         remain_ff     <= remain_in;
         offset_ff     <= offset_in;
         frag_word_ff  <= frag_word_in;
         frag_state_ff <= frag_state_in;
         frag_found_ff <= frag_found_in;
         frag_pos_ff   <= frag_pos_in;
         active_ff     <= active_in;
      end
   end

endmodule

`default_nettype wire

// File: dv/ipv6_ext_header_walker_tb.sv
// ----------------------------------------------------------------------------
// ipv6_ext_header_walker_tb - self-checking bench for the extension header walker
// Feeds byte streams of extension header chains (well formed, truncated,
// overrun, restarted and noise) and checks every walk result against an
// in-bench model of the chain walk, under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------

module ipv6_ext_header_walker_tb
   import v6ehw_pkg::*;
;

   // cycles with no handshake on either channel before giving up
   localparam int QUIET_LIMIT = 4000;
   // a result is taken only after its request has passed both registers; leave margin
   localparam int DRAIN_CYCLES = 16;
   // random bytes per idle phase
   localparam int PHASE_BYTES = 500;

   logic clock;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_first_byte = 1'b0;
   logic        req_last_byte = 1'b0;
   logic [7:0]  req_initial_next_header = '0;
   logic [15:0] req_available_length = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_walk_ok;
   logic [7:0]  rsp_next_protocol;
   logic [1:0]  rsp_frag_flags;
   logic [15:0] rsp_consumed_length;
   logic        rsp_frag_header_seen;
   logic [15:0] rsp_frag_header_offset;

   ipv6_ext_header_walker u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .req_first_byte         (req_first_byte),
      .req_last_byte          (req_last_byte),
      .req_initial_next_header(req_initial_next_header),
      .req_available_length   (req_available_length),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_walk_ok            (rsp_walk_ok),
      .rsp_next_protocol      (rsp_next_protocol),
      .rsp_frag_flags         (rsp_frag_flags),
      .rsp_consumed_length    (rsp_consumed_length),
      .rsp_frag_header_seen   (rsp_frag_header_seen),
      .rsp_frag_header_offset (rsp_frag_header_offset)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // --------------------------------------------------------------------------
   // Bench state
   // --------------------------------------------------------------------------
   item_type   byte_q[$];         // bytes waiting to be driven
   result_type walk_results_q[$]; // walk results predicted, not yet seen

   int   send_idle_pct = 0;       // chance per cycle that the sender holds off
   int   stall_pct = 0;           // chance per cycle that rsp_ready is low
   logic req_fire = 1'b0;         // request taken at the last rising edge
   int   quiet_cycles = 0;

   int mismatches = 0;
   int chains_queued = 0;
   int bytes_queued = 0;
   int results_checked = 0;
   int ok_walks = 0;
   int failed_walks = 0;
   int later_frags = 0;

   // --------------------------------------------------------------------------
   // Walk model: its own copy of the chain state
   // --------------------------------------------------------------------------
   logic [7:0]       cur_proto;
   logic [7:0]       nxt_hdr;     // next-header byte of the header in progress
   logic [IDX_W-1:0] hdr_idx;     // 0 at a header boundary
   logic [IDX_W-1:0] hdr_last;    // header size minus one
   logic [LEN_W-1:0] remain;
   logic [LEN_W-1:0] walked;      // bytes of completed headers
   logic [15:0]      frag_wd;
   logic [1:0]       frag_bits;
   logic             frag_seen;
   logic [LEN_W-1:0] frag_at;
   logic             walking = 1'b0;

   function automatic logic ext_proto(input logic [7:0] proto);
      case (proto)
         PROTO_HOPOPTS, PROTO_ROUTING, PROTO_DSTOPTS, PROTO_AH, PROTO_FRAGMENT:
            return 1'b1;
         default:
            return 1'b0;
      endcase
   endfunction

   // closes the walk and builds its result
   function automatic result_type walk_done(input logic ok, input logic [7:0] proto);
      result_type r;
      r.walk_ok = ok;
      r.next_protocol = proto;
      r.frag_flags = frag_bits;
      r.consumed_length = 16'(walked);
      r.frag_header_seen = frag_seen;
      r.frag_header_offset = frag_seen ? 16'(frag_at) : 16'd0;
      walking = 1'b0;
      return r;
   endfunction

   // advances the walk by one byte; returns 1 when the walk ends here
   function automatic logic walk_step(input item_type it, output result_type res);
      logic [16:0] hdr_len;
      logic        in_frag;
      res = '0;
      if (it.first_byte) begin
         // a new chain; any walk in flight is dropped without a result
         cur_proto = it.initial_next_header;
         remain = LEN_W'(it.available_length);
         nxt_hdr = '0;
         hdr_idx = '0;
         hdr_last = '0;
         walked = '0;
         frag_wd = '0;
         frag_bits = '0;
         frag_seen = 1'b0;
         frag_at = '0;
         walking = 1'b1;
      end
      if (!walking)
         return 1'b0;

      if (hdr_idx == 0) begin
         // boundary: upper layer ends the walk without taking the byte
         if (!ext_proto(cur_proto)) begin
            res = walk_done(1'b1, cur_proto);
            return 1'b1;
         end
         if (remain < MIN_HDR_BYTES) begin
            res = walk_done(1'b0, cur_proto);
            return 1'b1;
         end
         nxt_hdr = it.data_byte;
         if (cur_proto == PROTO_FRAGMENT) begin
            frag_seen = 1'b1;
            frag_at = walked;
            hdr_last = FRAG_HDR_LAST;
            frag_wd = '0;
         end
         hdr_idx = IDX_W'(1);
      end else begin
         in_frag = (cur_proto == PROTO_FRAGMENT);
         if (hdr_idx == 1 && !in_frag) begin
            if (cur_proto == PROTO_AH)
               hdr_len = (17'(it.data_byte) + 17'd2) * 17'd4;
            else
               hdr_len = (17'(it.data_byte) + 17'd1) * 17'd8;
            // header runs past the available bytes
            if (hdr_len > 17'(remain)) begin
               res = walk_done(1'b0, nxt_hdr);
               return 1'b1;
            end
            hdr_last = IDX_W'(hdr_len - 17'd1);
         end
         if (in_frag && hdr_idx == 2)
            frag_wd = {it.data_byte, 8'h00};
         if (in_frag && hdr_idx == 3)
            frag_wd[7:0] = it.data_byte;
         if (hdr_idx >= hdr_last) begin
            remain = remain - LEN_W'(hdr_last) - LEN_W'(1);
            walked = walked + LEN_W'(hdr_last) + LEN_W'(1);
            cur_proto = nxt_hdr;
            hdr_idx = '0;
            // an all-zero fragment word leaves the flags alone
            if (in_frag && frag_wd != 0) begin
               frag_bits = 2'b01;
               if ((frag_wd & FRAG_OFFSET_MASK) != 0) begin
                  frag_bits = 2'b11;
                  res = walk_done(1'b1, PROTO_FRAGMENT);
                  return 1'b1;
               end
            end
         end else begin
            hdr_idx = hdr_idx + IDX_W'(1);
         end
      end

      if (it.last_byte) begin
         if (hdr_idx == 0 && !ext_proto(cur_proto))
            res = walk_done(1'b1, cur_proto);
         else
            res = walk_done(1'b0, cur_proto);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // --------------------------------------------------------------------------
   // Driver: request channel from byte_q, rsp_ready at random
   // --------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      item_type nxt;
      if (!reset) begin
         // only move on once the current request has gone through
         if (!req_valid || req_fire) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = byte_q.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= nxt.data_byte;
               req_first_byte <= nxt.first_byte;
               req_last_byte <= nxt.last_byte;
               req_initial_next_header <= nxt.initial_next_header;
               req_available_length <= nxt.available_length;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // --------------------------------------------------------------------------
   // Monitor: check results, then predict from the request taken
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      result_type want;
      result_type seen;
      item_type   taken;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;

         if (rsp_valid && rsp_ready) begin
            seen.walk_ok = rsp_walk_ok;
            seen.next_protocol = rsp_next_protocol;
            seen.frag_flags = rsp_frag_flags;
            seen.consumed_length = rsp_consumed_length;
            seen.frag_header_seen = rsp_frag_header_seen;
            seen.frag_header_offset = rsp_frag_header_offset;
            results_checked++;
            if (seen.walk_ok) ok_walks++;
            else failed_walks++;
            if (seen.frag_flags[1]) later_frags++;
            if (walk_results_q.size() == 0) begin
               $error("result with no walk pending: walk_ok %0d next_protocol %0d",
                      seen.walk_ok, seen.next_protocol);
               mismatches++;
            end else begin
               want = walk_results_q.pop_front();
               if (seen.walk_ok !== want.walk_ok) begin
                  $error("walk_ok: expected %0d, got %0d", want.walk_ok, seen.walk_ok);
                  mismatches++;
               end
               if (seen.next_protocol !== want.next_protocol) begin
                  $error("next_protocol: expected %0d, got %0d",
                         want.next_protocol, seen.next_protocol);
                  mismatches++;
               end
               if (seen.frag_flags !== want.frag_flags) begin
                  $error("frag_flags: expected %0d, got %0d",
                         want.frag_flags, seen.frag_flags);
                  mismatches++;
               end
               if (seen.consumed_length !== want.consumed_length) begin
                  $error("consumed_length: expected %0d, got %0d",
                         want.consumed_length, seen.consumed_length);
                  mismatches++;
               end
               if (seen.frag_header_seen !== want.frag_header_seen) begin
                  $error("frag_header_seen: expected %0d, got %0d",
                         want.frag_header_seen, seen.frag_header_seen);
                  mismatches++;
               end
               if (seen.frag_header_offset !== want.frag_header_offset) begin
                  $error("frag_header_offset: expected %0d, got %0d",
                         want.frag_header_offset, seen.frag_header_offset);
                  mismatches++;
               end
            end
         end

         // a result is taken only after its request has passed the input and output
         // registers, so predicting after the check is safe
         if (req_valid && req_ready) begin
            taken.data_byte = req_data_byte;
            taken.first_byte = req_first_byte;
            taken.last_byte = req_last_byte;
            taken.initial_next_header = req_initial_next_header;
            taken.available_length = req_available_length;
            if (walk_step(taken, want))
               walk_results_q.push_back(want);
         end
      end
   end

   // watchdog: nothing moving on either channel for too long
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, walk_results_q.size());
         $display("FAIL ipv6_ext_header_walker");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   task automatic queue_byte(input logic [7:0] data, input logic first, input logic last,
                             input logic [7:0] nh, input logic [15:0] avail);
      item_type it;
      it.data_byte = data;
      it.first_byte = first;
      it.last_byte = last;
      it.initial_next_header = nh;
      it.available_length = avail;
      byte_q.push_back(it);
   endtask

   // builds one chain of 0..4 extension headers, upper layer and a few payload
   // bytes; available length and stream end are mostly right, sometimes not
   task automatic queue_chain(output int n_bytes);
      logic [7:0]  chain[$];
      logic [7:0]  protos[$];
      logic [7:0]  lb;
      logic [15:0] fw;
      logic [15:0] avail;
      int          n_hdr;
      int          size;
      int          cut;
      int          mode;
      n_hdr = $urandom_range(0, 4);
      for (int i = 0; i < n_hdr; i++) begin
         case ($urandom_range(4))
            0: protos.push_back(PROTO_HOPOPTS);
            1: protos.push_back(PROTO_ROUTING);
            2: protos.push_back(PROTO_DSTOPTS);
            3: protos.push_back(PROTO_AH);
            default: protos.push_back(PROTO_FRAGMENT);
         endcase
      end
      // upper layer: TCP, UDP, ICMPv6, no-next-header or anything at all
      case ($urandom_range(5))
         0: protos.push_back(8'd6);
         1: protos.push_back(8'd17);
         2: protos.push_back(8'd58);
         3: protos.push_back(8'd59);
         default: protos.push_back(8'($urandom));
      endcase

      for (int i = 0; i < n_hdr; i++) begin
         chain.push_back(protos[i + 1]);
         if (protos[i] == PROTO_FRAGMENT) begin
            // zero word, first fragment, or later fragment
            case ($urandom_range(3))
               0: fw = '0;
               1: fw = 16'($urandom_range(1, 7));
               default: fw = {13'($urandom_range(1, 8191)), 3'($urandom_range(7))};
            endcase
            chain.push_back(8'($urandom));
            chain.push_back(fw[15:8]);
            chain.push_back(fw[7:0]);
            repeat (4) chain.push_back(8'($urandom));
         end else begin
            // mostly short headers, now and then the longest one
            if ($urandom_range(199) == 0)
               lb = 8'hFF;
            else if ($urandom_range(9) == 0)
               lb = 8'($urandom_range(3, 15));
            else
               lb = 8'($urandom_range(2));
            size = (protos[i] == PROTO_AH) ? (int'(lb) + 2) * 4 : (int'(lb) + 1) * 8;
            chain.push_back(lb);
            repeat (size - 2) chain.push_back(8'($urandom));
         end
      end
      repeat ($urandom_range(0, 6)) chain.push_back(8'($urandom));
      if (chain.size() == 0)
         chain.push_back(8'($urandom));

      mode = $urandom_range(99);
      if (mode < 70)
         avail = 16'(chain.size());
      else if (mode < 80)
         avail = 16'($urandom_range(65535, chain.size()));
      else if (mode < 90)
         avail = 16'($urandom_range(chain.size(), 0));
      else
         avail = 16'($urandom);

      // stream end: usually on the last byte, sometimes early, sometimes never
      mode = $urandom_range(99);
      cut = chain.size();
      if (mode >= 80 && mode < 90)
         cut = $urandom_range(chain.size(), 1);
      for (int i = 0; i < cut; i++) begin
         if (i == 0)
            queue_byte(chain[i], 1'b1, (mode < 90) && (cut == 1), protos[0], avail);
         else
            queue_byte(chain[i], 1'b0, (mode < 90) && (i == cut - 1),
                       8'($urandom), 16'($urandom));
      end
      chains_queued++;
      bytes_queued += cut;
      n_bytes = cut;
   endtask

   // one idle mix: queue random chains, then wait for every result
   task automatic run_phase(input int idle, input int stall, input int target);
      int n;
      int sent;
      send_idle_pct = idle;
      stall_pct = stall;
      sent = 0;
      while (sent < target) begin
         // stray bytes with first_byte low between chains
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3))
               queue_byte(8'($urandom), 1'b0, 1'($urandom), 8'($urandom), 16'($urandom));
         end
         queue_chain(n);
         sent += n;
      end
      while (byte_q.size() != 0 || req_valid)
         @(posedge clock);
      while (walk_results_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening
      // byte with no walk running: dropped
      queue_byte(8'hFF, 1'b0, 1'b0, 8'd0, 16'hFFFF);
      // upper layer at once, largest available length
      queue_byte(8'h00, 1'b1, 1'b0, 8'd6, 16'hFFFF);
      // hop-by-hop with only 7 bytes left
      queue_byte(8'h11, 1'b1, 1'b0, PROTO_HOPOPTS, 16'd7);
      // destination options with nothing available, last byte at once
      queue_byte(8'hFF, 1'b1, 1'b1, PROTO_DSTOPTS, 16'd0);
      // AH of exactly 8 bytes, stream ends on a clean boundary
      queue_byte(8'd17, 1'b1, 1'b0, PROTO_AH, 16'd8);
      queue_byte(8'h00, 1'b0, 1'b0, 8'hFF, 16'hFFFF);
      for (int i = 0; i < 5; i++)
         queue_byte(8'hA5, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h5A, 1'b0, 1'b1, 8'h00, 16'h0000);
      // routing header claiming 2048 bytes of 8: overrun on the length byte
      queue_byte(8'd6, 1'b1, 1'b0, PROTO_ROUTING, 16'd8);
      queue_byte(8'hFF, 1'b0, 1'b0, 8'h00, 16'h0000);
      // later fragment ends the walk
      queue_byte(8'd58, 1'b1, 1'b0, PROTO_FRAGMENT, 16'd16);
      queue_byte(8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h01, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
      for (int i = 0; i < 4; i++)
         queue_byte(8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
      // restart in the middle of a hop-by-hop header
      queue_byte(8'd6, 1'b1, 1'b0, PROTO_HOPOPTS, 16'd100);
      queue_byte(8'h00, 1'b0, 1'b0, 8'h00, 16'h0000);
      queue_byte(8'hFF, 1'b1, 1'b0, 8'd17, 16'd100);

      // random chains under each idle mix
      run_phase(0, 0, PHASE_BYTES);
      run_phase(88, 0, PHASE_BYTES);
      run_phase(0, 88, PHASE_BYTES);
      run_phase(35, 35, PHASE_BYTES);

      if (walk_results_q.size() != 0) begin
         $error("%0d walk results never arrived", walk_results_q.size());
         mismatches++;
      end
      $display("walked %0d random chains (%0d bytes) plus directed cases under 4 idle mixes",
               chains_queued, bytes_queued);
      $display("checked %0d results: %0d parsed, %0d failed, %0d later fragments",
               results_checked, ok_walks, failed_walks, later_frags);
      if (mismatches == 0)
         $display("PASS ipv6_ext_header_walker");
      else
         $display("FAIL ipv6_ext_header_walker");
      $finish;
   end

endmodule

// File: ipv6_ext_header_walker.f
hdl/v6ehw_pkg.sv
hdl/v6ehw_walk.sv
hdl/ipv6_ext_header_walker.sv
dv/ipv6_ext_header_walker_tb.sv
